[sv/msd_pkg.sv]
// Shared types and constants of the multichannel sample delay.
package msd_pkg;

    // Number of per-channel delay registers and width of a delay setting.
    localparam int NUM_DELAY_REGS   = 4;
    localparam int DELAY_CFG_BITS   = 13;
    localparam int CFG_ADDR_BITS    = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int WORD_BITS        = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_BITS-1:0] REG_DELAY_CHAN0 = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DELAY_CHAN1 = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DELAY_CHAN2 = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DELAY_CHAN3 = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SILENCE     = 3'd4;

    typedef logic [DELAY_CFG_BITS-1:0] delay_cfg_t;

    typedef struct packed {
        logic [1:0]           chan_index;
        logic [WORD_BITS-1:0] sample_in;
        logic                 block_end;
    } in_t;

    typedef struct packed {
        logic [1:0]           chan_out;
        logic [WORD_BITS-1:0] sample_out;
        logic                 block_end_out;
    } out_t;

    // Per-request decision of the position tracker, handed to the output pipeline.
    typedef struct packed {
        logic use_mem;
        logic filled;
    } ctl_t;

endpackage

[sv/msd_cfg.sv]
// Configuration registers: per-channel delays and the silence word.
module msd_cfg
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [msd_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [msd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output msd_pkg::delay_cfg_t                   delay [msd_pkg::NUM_DELAY_REGS],
    output logic [msd_pkg::WORD_BITS-1:0]         silence
);

    msd_pkg::delay_cfg_t              delay_reg [msd_pkg::NUM_DELAY_REGS];
    logic [msd_pkg::WORD_BITS-1:0]    silence_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msd_pkg::NUM_DELAY_REGS; i++)
            begin
                delay_reg[i] <= '0;
            end
            silence_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr) inside
                msd_pkg::REG_DELAY_CHAN0, msd_pkg::REG_DELAY_CHAN1,
                msd_pkg::REG_DELAY_CHAN2, msd_pkg::REG_DELAY_CHAN3:
                begin
                    delay_reg[cfg_addr[1:0]] <= cfg_wdata[msd_pkg::DELAY_CFG_BITS-1:0];
                end
                msd_pkg::REG_SILENCE:
                begin
                    silence_reg <= cfg_wdata[msd_pkg::WORD_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign delay   = delay_reg;
    assign silence = silence_reg;

endmodule

[sv/msd_track.sv]
// Per-channel write position and fill tracking, and memory address generation.
module msd_track
#(
    parameter int CHANNELS  = 4,
    parameter int MAX_DELAY = 4096,
    parameter int ADDR_BITS = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             chan,
    input  msd_pkg::delay_cfg_t    delay [msd_pkg::NUM_DELAY_REGS],
    output logic [ADDR_BITS-1:0]   addr,
    output msd_pkg::ctl_t          ctl
);

    localparam int POS_BITS  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DLY_WIDTH = $clog2(MAX_DELAY + 1);
    localparam int EFF_BITS  = (DLY_WIDTH > msd_pkg::DELAY_CFG_BITS) ?
                               DLY_WIDTH : msd_pkg::DELAY_CFG_BITS;

    logic [POS_BITS-1:0]  wpos_reg   [msd_pkg::NUM_DELAY_REGS];
    logic [POS_BITS-1:0]  wpos_next;
    logic                 filled_reg [msd_pkg::NUM_DELAY_REGS];
    logic [EFF_BITS-1:0]  dly_cfg;
    logic [EFF_BITS-1:0]  dly_eff;
    logic [POS_BITS-1:0]  pos_cur;
    logic [EFF_BITS-1:0]  pos_inc;
    logic                 wrap;
    logic                 present;

    always_comb
    begin
        present = (int'(chan) < CHANNELS);
        dly_cfg = EFF_BITS'(delay[chan]);
        dly_eff = (dly_cfg > EFF_BITS'(MAX_DELAY)) ? EFF_BITS'(MAX_DELAY) : dly_cfg;
        // A position left beyond a shortened delay starts over at the region base.
        pos_cur = (EFF_BITS'(wpos_reg[chan]) >= dly_eff) ? '0 : wpos_reg[chan];
        pos_inc = EFF_BITS'(pos_cur) + EFF_BITS'(1);
        wrap    = (pos_inc >= dly_eff);
        wpos_next = wrap ? '0 : pos_inc[POS_BITS-1:0];
        addr    = (ADDR_BITS'(chan) * ADDR_BITS'(MAX_DELAY)) + ADDR_BITS'(pos_cur);
        ctl.use_mem = present && (dly_eff != '0);
        ctl.filled  = filled_reg[chan];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msd_pkg::NUM_DELAY_REGS; i++)
            begin
                wpos_reg[i]   <= '0;
                filled_reg[i] <= 1'b0;
            end
        end
        else if (accept && ctl.use_mem)
        begin
            wpos_reg[chan] <= wpos_next;
            if (wrap)
            begin
                filled_reg[chan] <= 1'b1;
            end
        end
    end

endmodule

[sv/msd_ram.sv]
// Single-port delay store with read-before-write and registered read data.
module msd_ram
#(
    parameter int DEPTH     = 16384,
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ADDR_BITS-1:0]  addr,
    input  logic [DATA_BITS-1:0]  wdata,
    output logic [DATA_BITS-1:0]  rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // The old word is read out in the same cycle the new sample replaces it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/msd_pipe.sv]
// Handshake pipeline: memory read stage followed by the output register.
module msd_pipe
#(
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  msd_pkg::in_t                   in_data,
    output logic                           accept,
    input  msd_pkg::ctl_t                  ctl,
    input  logic [SAMPLE_BITS-1:0]         rdata,
    input  logic [msd_pkg::WORD_BITS-1:0]  silence,
    output logic                           out_valid,
    input  logic                           out_ready,
    output msd_pkg::out_t                  out_data
);

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [1:0]              s1_chan_reg;
    logic [SAMPLE_BITS-1:0]  s1_sample_reg;
    logic                    s1_end_reg;
    msd_pkg::ctl_t           s1_ctl_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    msd_pkg::out_t           out_data_reg;
    logic                    out_free;
    logic                    s1_move;
    logic [SAMPLE_BITS-1:0]  s1_result;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        s1_move        = s1_valid_reg && out_free;
        in_ready       = !s1_valid_reg || s1_move;
        accept         = in_valid && in_ready;
        s1_valid_next  = accept || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
        if (!s1_ctl_reg.use_mem)
        begin
            s1_result = s1_sample_reg;
        end
        else if (s1_ctl_reg.filled)
        begin
            s1_result = rdata;
        end
        else
        begin
            s1_result = silence[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg   <= in_data.chan_index;
            s1_sample_reg <= in_data.sample_in[SAMPLE_BITS-1:0];
            s1_end_reg    <= in_data.block_end;
            s1_ctl_reg    <= ctl;
        end
        if (s1_move)
        begin
            out_data_reg.chan_out      <= s1_chan_reg;
            out_data_reg.sample_out    <= msd_pkg::WORD_BITS'(s1_result);
            out_data_reg.block_end_out <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/multichannel_sample_delay.sv]
// A request accepted is registered into the read stage, together with the store read,
// and then moves on into the output register, from which its result leaves.
// Throughput: one request per cycle while the output is not stalled, set by the single read-before-write store port.
// The store is read and written in the acceptance cycle; the result leaves through
// a read stage and an output register, so input is taken while a result waits.
// Reset clears positions, fill flags, configuration registers and valid flags; store contents are not cleared.
module multichannel_sample_delay
#(
    parameter int CHANNELS    = 4,
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  msd_pkg::in_t                         in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output msd_pkg::out_t                        out_data,
    input  logic                                 cfg_wen,
    input  logic [msd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [msd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int USED_CHANS = (CHANNELS < msd_pkg::NUM_DELAY_REGS) ?
                                CHANNELS : msd_pkg::NUM_DELAY_REGS;
    localparam int DEPTH      = USED_CHANS * MAX_DELAY;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    msd_pkg::delay_cfg_t            delay [msd_pkg::NUM_DELAY_REGS];
    logic [msd_pkg::WORD_BITS-1:0]  silence;
    logic                           accept;
    logic [ADDR_BITS-1:0]           addr;
    msd_pkg::ctl_t                  ctl;
    logic [SAMPLE_BITS-1:0]         rdata;

    msd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .delay     (delay),
        .silence   (silence)
    );

    msd_track
    #(
        .CHANNELS  (CHANNELS),
        .MAX_DELAY (MAX_DELAY),
        .ADDR_BITS (ADDR_BITS)
    )
    u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .chan   (in_data.chan_index),
        .delay  (delay),
        .addr   (addr),
        .ctl    (ctl)
    );

    msd_ram
    #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (SAMPLE_BITS)
    )
    u_ram
    (
        .clk   (clk),
        .en    (accept && ctl.use_mem),
        .addr  (addr),
        .wdata (in_data.sample_in[SAMPLE_BITS-1:0]),
        .rdata (rdata)
    );

    msd_pipe
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .accept    (accept),
        .ctl       (ctl),
        .rdata     (rdata),
        .silence   (silence),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[sv/msd_check.sv]
// Port-level checker for the multichannel sample delay, bound to the top level.
module msd_check
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  logic           out_valid,
    input  logic           out_ready,
    input  msd_pkg::out_t  out_data
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // Requests accepted whose results have not yet been taken.
    always_comb
    begin
        cnt_next = cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result shown without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("more requests in flight than pipeline stages");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !out_ready |-> !in_ready)
        else $error("request taken while both stages are full and stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> in_ready)
        else $error("empty block refused a request");

endmodule

bind multichannel_sample_delay msd_check u_check (.*);
